### hw/rtl/ppc_pkg.sv
// Package: shared constants, register indexes and the character class decoder.
package ppc_pkg;

  localparam int unsigned MAX_LEN_DEF = 128;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARAM = 2'd1;

  // class bits
  localparam int unsigned CL_LOWER   = 0;
  localparam int unsigned CL_UPPER   = 1;
  localparam int unsigned CL_DIGIT   = 2;
  localparam int unsigned CL_SPECIAL = 3;

  // fail flag bits
  localparam int unsigned FL_RUN    = 0;
  localparam int unsigned FL_REPEAT = 1;
  localparam int unsigned FL_LONG   = 2;

  localparam logic [7:0] SAT_MAX = 8'd255;

  function automatic logic [3:0] class_of(input logic [7:0] c);
    logic [3:0] cl;
    cl = 4'b0000;
    if (c >= 8'd97 && c <= 8'd122) begin
      cl[CL_LOWER] = 1'b1;
    end else if (c >= 8'd65 && c <= 8'd90) begin
      cl[CL_UPPER] = 1'b1;
    end else if (c >= 8'd48 && c <= 8'd57) begin
      cl[CL_DIGIT] = 1'b1;
    end else if ((c >= 8'd32 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                 (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126)) begin
      cl[CL_SPECIAL] = 1'b1;
    end
    return cl;
  endfunction

endpackage

### hw/rtl/password_policy_checker_top.sv
// Top level: password policy checker with character and match-length memories.
//
//  channel | dir | handshake                 | payload
//  s_*     | in  | s_tvalid / s_tready       | tdata char_code, tuser has_char, tlast is_last
//  m_*     | out | m_tvalid / m_tready       | tdata pass, rule1..4_ok, too_long
//  cfg_*   | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data (ready always high)
//
// A character stored at position p (p >= 1) walks the match-length memory through every
// earlier position, then drains before the next beat is accepted. A first character,
// an overlong one or an empty beat skips the walk; a last beat also loads the result
// register in ST_FIN, where it waits for the output to be free.
// Synchronous reset clears control state only; memories are not cleared.
// A waiting result does not block input; only a new last beat waits on m_tready.
module password_policy_checker_top #(
  parameter int unsigned MAX_LEN = ppc_pkg::MAX_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] char_code
  input  logic                             s_tuser,   // [0] has_char
  input  logic                             s_tlast,   // is_last
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,   // [0] pass, [1] rule1_ok, [2] rule2_ok,
                                                      // [3] rule3_ok, [4] rule4_ok,
                                                      // [5] too_long, [7:6] zero
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ppc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned PW = $clog2(MAX_LEN + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_LEN);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [7:0] char_mem [MAX_LEN];
  logic [7:0] ml_mem   [MAX_LEN];

  logic [PW-1:0] pos;
  logic [7:0]    prev_char;
  logic [7:0]    run_len;
  logic [3:0]    classes;
  logic [2:0]    flags;
  logic [2:0]    level;
  logic [6:0]    param;

  logic [7:0]    cur_char;
  logic [6:0]    param_q;
  logic          last_q;
  logic [AW-1:0] walk_k;

  logic          p_vld;
  logic [AW-1:0] p_k;
  logic          p_zero;
  logic [7:0]    rd_char;
  logic [7:0]    rd_ml;

  logic          acc;
  logic          store;
  logic          walk;
  logic [7:0]    run_next;
  logic [2:0]    acc_flags;
  logic [AW-1:0] ml_raddr;
  logic [7:0]    prev_len;
  logic [7:0]    len;
  logic          ml_we;
  logic [AW-1:0] ml_waddr;
  logic [7:0]    ml_wdata;
  logic          out_free;

  logic          r1, r2, r3, r4, too_long, pass_v;
  logic [2:0]    need;
  logic [2:0]    cnt;
  logic [2:0]    lv;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign acc       = s_tvalid & s_tready;
  assign store     = acc & s_tuser & (pos < POS_MAX);
  assign walk      = store & (pos != '0);
  assign out_free  = ~m_tvalid | m_tready;

  assign run_next = ((pos != '0) && (s_tdata == prev_char)) ?
                    ((run_len == SAT_MAX) ? SAT_MAX : run_len + 8'd1) : 8'd1;

  // flags raised by an accepted character
  always_comb begin
    acc_flags            = '0;
    acc_flags[FL_RUN]    = (run_next >= 8'd2) && (run_next >= {1'b0, param});
    acc_flags[FL_LONG]   = (pos >= POS_MAX);
  end

  // Walk downward: ml[k-1] is read into rd_ml before ml[k-1] itself is rewritten.
  assign ml_raddr = (walk_k == '0) ? '0 : walk_k - AW'(1);
  assign prev_len = p_zero ? 8'd0 : rd_ml;
  assign len      = (rd_char == cur_char) ?
                    ((prev_len == SAT_MAX) ? SAT_MAX : prev_len + 8'd1) : 8'd0;

  always_comb begin
    ml_we    = 1'b0;
    ml_waddr = p_k;
    ml_wdata = len;
    if (p_vld) begin
      ml_we = 1'b1;
    end else if (store) begin
      ml_we    = 1'b1;
      ml_waddr = pos[AW-1:0];
      ml_wdata = 8'd0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (walk) begin
            state_next = ST_WALK;
          end else if (s_tlast) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_WALK: begin
        if (walk_k == '0) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // verdicts
  assign r1       = classes[CL_LOWER] & classes[CL_UPPER];
  assign need     = (param >= 7'd4) ? 3'd4 : param[2:0];
  assign cnt      = 3'($countones(classes));
  assign r2       = (cnt >= need);
  assign r3       = (param >= 7'd2) & ~flags[FL_RUN];
  assign r4       = (param >= 7'd1) & ~flags[FL_REPEAT];
  assign too_long = flags[FL_LONG];
  assign lv       = (level > 3'd4) ? 3'd4 : level;
  assign pass_v   = ~too_long & ((lv < 3'd1) | r1) & ((lv < 3'd2) | r2) &
                    ((lv < 3'd3) | r3) & ((lv < 3'd4) | r4);

  always_ff @(posedge clk) begin
    if (store) begin
      char_mem[pos[AW-1:0]] <= s_tdata;
    end
    if (ml_we) begin
      ml_mem[ml_waddr] <= ml_wdata;
    end
    rd_char <= char_mem[walk_k];
    rd_ml   <= ml_mem[ml_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cur_char <= s_tdata;
      param_q  <= param;
      last_q   <= s_tlast;
      walk_k   <= pos[AW-1:0] - AW'(1);
    end else if (state == ST_WALK && walk_k != '0) begin
      walk_k <= walk_k - AW'(1);
    end
    p_k    <= walk_k;
    p_zero <= (walk_k == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      prev_char <= '0;
      run_len   <= '0;
      classes   <= '0;
      flags     <= '0;
      level     <= 3'd1;
      param     <= 7'd1;
      p_vld     <= 1'b0;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
    end else begin
      state <= state_next;
      p_vld <= (state == ST_WALK);

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEVEL: level <= cfg_data[2:0];
          CFG_PARAM: param <= cfg_data;
          default: ;
        endcase
      end

      if (acc && s_tuser) begin
        classes   <= classes | class_of(s_tdata);
        run_len   <= run_next;
        prev_char <= s_tdata;
        flags     <= flags | acc_flags;
        if (pos < POS_MAX) begin
          pos <= pos + PW'(1);
        end
      end

      if (p_vld && param_q >= 7'd1 && len >= {1'b0, param_q}) begin
        flags[FL_REPEAT] <= 1'b1;
      end

      if (state == ST_FIN && out_free) begin
        m_tvalid  <= 1'b1;
        m_tdata   <= {2'b00, too_long, r4, r3, r2, r1, pass_v};
        pos       <= '0;
        prev_char <= '0;
        run_len   <= '0;
        classes   <= '0;
        flags     <= '0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/ppc_checker.sv
// Checker: port-level properties of the password policy checker, bound to the top.
module ppc_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       cfg_ready
);

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  a_pass_not_long: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[5])
    else $error("pass with too_long set");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:6] == 2'b00) && cfg_ready)
    else $error("result padding not zero or cfg stalled");

endmodule

bind password_policy_checker_top ppc_checker u_ppc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .cfg_ready(cfg_ready)
);

### bench/testbench.sv
// Self-checking bench for the password policy checker: random passwords against a built-in predictor.
`timescale 1ns / 1ps

module testbench;
  import ppc_pkg::*;

  localparam int unsigned MAX_LEN      = ppc_pkg::MAX_LEN_DEF;
  localparam int unsigned SETTLE_CYC   = MAX_LEN + 8;
  localparam int unsigned STALL_CYC    = 400;
  localparam int unsigned DRAIN_CYC    = 10000;
  localparam int unsigned MAX_PRINTS   = 60;
  localparam longint unsigned TIMEOUT_NS = 64'd15_000_000;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       is_last;
  } beat_t;

  // msb first, so bit 0 is pass as on m_tdata
  typedef struct packed {
    logic [1:0] spare;
    logic       too_long;
    logic       rule4_ok;
    logic       rule3_ok;
    logic       rule2_ok;
    logic       rule1_ok;
    logic       pass;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'd0;   // [7:0] char_code
  logic                  s_tuser = 1'b0;   // [0] has_char
  logic                  s_tlast = 1'b0;   // is_last
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;          // [0] pass, [1..4] rule1..4_ok, [5] too_long
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  password_policy_checker_top #(.MAX_LEN(MAX_LEN)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // traffic bookkeeping
  beat_t       beat_q[$];
  verdict_t    verdict_q[$];
  int unsigned beats_pushed = 0;
  int unsigned beats_taken = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned error_count = 0;
  bit          in_taken = 1'b0;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;
  int unsigned stall_asked = 0;
  int unsigned stall_served = 0;
  int unsigned stall_left = 0;

  string field_name [8] = '{"pass", "rule1_ok", "rule2_ok", "rule3_ok", "rule4_ok",
                            "too_long", "spare6", "spare7"};

  // predictor state
  logic [7:0]  pw_chars [MAX_LEN];
  int unsigned pw_match [MAX_LEN];
  int unsigned pw_pos = 0;
  logic [7:0]  pw_prev = 8'd0;
  int unsigned pw_run = 0;
  logic [3:0]  pw_classes = 4'd0;
  logic [2:0]  pw_flags = 3'd0;
  logic [2:0]  cur_level = 3'd1;
  logic [6:0]  cur_param = 7'd1;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic logic [3:0] char_class(input logic [7:0] c);
    logic [3:0] cl;
    cl = 4'd0;
    if (c >= "a" && c <= "z")      cl[CL_LOWER] = 1'b1;
    else if (c >= "A" && c <= "Z") cl[CL_UPPER] = 1'b1;
    else if (c >= "0" && c <= "9") cl[CL_DIGIT] = 1'b1;
    else if ((c >= 8'd32 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
             (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126))
      cl[CL_SPECIAL] = 1'b1;
    return cl;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    int unsigned j, k, len, prior;
    pw_classes = pw_classes | char_class(c);
    if (pw_pos != 0 && c == pw_prev) begin
      if (pw_run < 255) pw_run++;
    end else begin
      pw_run = 1;
    end
    if (pw_run >= 2 && pw_run >= cur_param) pw_flags[FL_RUN] = 1'b1;
    pw_prev = c;
    if (pw_pos >= MAX_LEN) begin
      pw_flags[FL_LONG] = 1'b1;
      return;
    end
    // top-down, so each entry reads its neighbor's match length from the previous char
    for (j = pw_pos; j > 0; j--) begin
      k = j - 1;
      len = 0;
      if (pw_chars[k] == c) begin
        prior = (k > 0) ? pw_match[k-1] : 0;
        len = (prior < 255) ? prior + 1 : 255;
      end
      pw_match[k] = len;
      if (cur_param >= 1 && len >= cur_param) pw_flags[FL_REPEAT] = 1'b1;
    end
    pw_chars[pw_pos] = c;
    pw_match[pw_pos] = 0;
    pw_pos++;
  endfunction

  function automatic bit judge_beat(input beat_t b, output verdict_t v);
    int unsigned need, lv;
    bit r1, r2, r3, r4, tl;
    v = '0;
    if (b.has_char) take_char(b.char_code);
    if (!b.is_last) return 1'b0;
    r1 = pw_classes[CL_LOWER] && pw_classes[CL_UPPER];
    need = (cur_param >= 4) ? 4 : cur_param;
    r2 = $countones(pw_classes) >= need;
    r3 = (cur_param >= 2) && !pw_flags[FL_RUN];
    r4 = (cur_param >= 1) && !pw_flags[FL_REPEAT];
    tl = pw_flags[FL_LONG];
    lv = (cur_level > 4) ? 4 : cur_level;
    v.pass = !tl && (lv < 1 || r1) && (lv < 2 || r2) && (lv < 3 || r3) && (lv < 4 || r4);
    v.rule1_ok = r1;
    v.rule2_ok = r2;
    v.rule3_ok = r3;
    v.rule4_ok = r4;
    v.too_long = tl;
    pw_pos = 0;
    pw_prev = 8'd0;
    pw_run = 0;
    pw_classes = 4'd0;
    pw_flags = 3'd0;
    return 1'b1;
  endfunction

  // input side
  always @(negedge clk) begin : drive_beats
    beat_t b;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (beat_q.size() != 0 && (src_calm || $urandom_range(99) >= 11)) begin
        b = beat_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= b.char_code;
        s_tuser <= b.has_char;
        s_tlast <= b.is_last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output side, with the long hold-off counted here
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_asked != stall_served) begin
      stall_served <= stall_served + 1;
      stall_left <= STALL_CYC;
      m_tready <= 1'b0;
    end else begin
      m_tready <= sink_calm || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin : watch
    beat_t b;
    verdict_t got, want;
    int i;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEVEL: cur_level = cfg_data[2:0];
          CFG_PARAM: cur_param = cfg_data;
          default: ;
        endcase
      end
      if (in_taken) begin
        b.char_code = s_tdata;
        b.has_char = s_tuser;
        b.is_last = s_tlast;
        beats_taken++;
        if (judge_beat(b, want)) verdict_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = verdict_t'(m_tdata);
        results_seen++;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result %0d (%b) with none expected", results_seen, m_tdata));
        end else begin
          want = verdict_q.pop_front();
          for (i = 0; i < 8; i++) begin
            if (got[i] !== want[i])
              report_mismatch($sformatf("result %0d %s: got %b want %b",
                                        results_seen, field_name[i], got[i], want[i]));
          end
        end
      end
    end
  end

  task automatic push_beat(input logic [7:0] c, input bit has, input bit last);
    beat_t b;
    b.char_code = c;
    b.has_char = has;
    b.is_last = last;
    beat_q.push_back(b);
    beats_pushed++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_beat(s[i], 1'b1, i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0, 1, 2: return 8'($urandom_range("z", "a"));
      3, 4:    return 8'($urandom_range("Z", "A"));
      5, 6:    return 8'($urandom_range("9", "0"));
      7, 8: begin
        case ($urandom_range(3))
          0:       return 8'($urandom_range(47, 32));
          1:       return 8'($urandom_range(64, 58));
          2:       return 8'($urandom_range(96, 91));
          default: return 8'($urandom_range(126, 123));
        endcase
      end
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)  return 0;
    if (r < 75) return $urandom_range(12, 1);
    if (r < 95) return $urandom_range(40, 13);
    return $urandom_range(100, 41);
  endfunction

  // runs and copied segments make rules 3 and 4 trip often; returns the beats that count
  task automatic push_password(input int unsigned len, output int unsigned counted);
    logic [7:0] txt[$];
    int unsigned pick, from, seg, k, i;
    bit close_empty;
    counted = 0;
    if (len == 0) begin
      push_beat(8'($urandom_range(255)), 1'b0, 1'b1);
      counted = 1;
      return;
    end
    while (txt.size() < len) begin
      pick = $urandom_range(9);
      if (pick < 2 && txt.size() != 0) begin
        txt.push_back(txt[txt.size()-1]);
      end else if (pick < 4 && txt.size() >= 2) begin
        from = $urandom_range(txt.size() - 2);
        seg = $urandom_range(6, 1);
        for (k = 0; k < seg && txt.size() < len; k++) txt.push_back(txt[from+k]);
      end else begin
        txt.push_back(pick_char());
      end
    end
    close_empty = ($urandom_range(11) == 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) push_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      push_beat(txt[i], 1'b1, !close_empty && i == len - 1);
      counted++;
    end
    if (close_empty) begin
      push_beat(8'($urandom_range(255)), 1'b0, 1'b1);
      counted++;
    end
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned done, got, i, tail;
    done = 0;
    while (done < n_items) begin
      push_password(pick_len(), got);
      done += got;
    end
    // leave a password open so the next setting lands mid-password
    if ($urandom_range(3) == 0) begin
      tail = $urandom_range(4, 1);
      for (i = 0; i < tail; i++) push_beat(pick_char(), 1'b1, 1'b0);
    end
  endtask

  task automatic settle();
    while (beats_taken != beats_pushed || verdict_q.size() != 0) @(negedge clk);
    // beats that end no password may still be walking the match memory
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_policy(input int unsigned lvl, input int unsigned prm);
    write_reg(CFG_LEVEL, CFG_DATA_W'(lvl));
    write_reg(CFG_PARAM, CFG_DATA_W'(prm));
  endtask

  initial begin : stimulus
    int unsigned p, i, lvl, prm, got, drain;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset policy: level 1, parameter 1
    push_beat(8'h00, 1'b0, 1'b0);   // empty beat, no result
    push_beat(8'hFF, 1'b0, 1'b1);   // empty password
    push_text("aZ");
    settle();
    set_policy(4, 3);
    push_text("aB3#");              // all classes, clean
    push_text("aaa");               // run reaches the limit
    push_text("abcXabc");           // repeated substring of length 3
    push_beat(8'h00, 1'b1, 1'b0);   // bytes of no class
    push_beat(8'hFF, 1'b1, 1'b0);
    push_beat(8'h7F, 1'b1, 1'b1);
    push_text("ab");                // shorter than the substring length
    settle();
    set_policy(0, 0);
    push_text("x");
    settle();
    set_policy(7, 127);
    push_text("Aa1");
    settle();

    for (p = 0; p < 16; p++) begin
      lvl = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
      case ($urandom_range(9))
        0:       prm = 0;
        1:       prm = 127;
        2:       prm = $urandom_range(127);
        default: prm = $urandom_range(8, 1);
      endcase
      case ($urandom_range(3))
        0:       write_reg(CFG_LEVEL, CFG_DATA_W'(lvl));
        1:       write_reg(CFG_PARAM, CFG_DATA_W'(prm));
        default: set_policy(lvl, prm);
      endcase
      if (p == 3) begin
        src_calm = 1'b1;
        sink_calm = 1'b1;
      end
      if (p == 6) begin
        // output held off while short passwords keep coming
        stall_asked++;
        for (i = 0; i < 40; i++) push_password($urandom_range(3, 1), got);
      end
      if (p == 9) begin
        set_policy(3, 100);
        for (i = 0; i < 300; i++) push_beat("a", 1'b1, i == 299);
        settle();
        set_policy(4, 2);
        push_password(135, got);
      end
      run_phase(60);
      settle();
      src_calm = 1'b0;
      sink_calm = 1'b0;
    end
    push_text("Zz9!");

    while (beats_taken != beats_pushed) @(negedge clk);
    for (drain = 0; drain < DRAIN_CYC && verdict_q.size() != 0; drain++) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));

    $display("checked %0d passwords over %0d beats with %0d register writes",
             results_seen, beats_taken, cfg_writes);
    $display("%s", {"covered empty and overlong passwords, edge policies, an output stall, ",
                    "and policy changes mid-password"});
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d verdicts outstanding", verdict_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
hw/rtl/ppc_pkg.sv
hw/rtl/password_policy_checker_top.sv
hw/rtl/ppc_checker.sv
bench/testbench.sv
